FILE: design/bfiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_pkg
// Shared types and codes of the Bloom filter insert and query block.
// ----------------------------------------------------------------------------
package bfiq_pkg;

    localparam int HASH_W = 16;
    localparam int SIZE_W = 13;
    localparam int PCNT_W = 6;
    localparam int OP_W   = 2;

    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [PCNT_W-1:0] t_pcnt;
    typedef logic [OP_W-1:0]   t_op;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_QUERY  = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;

    localparam logic REG_FILTER_SIZE = 1'b0;
    localparam logic REG_PROBE_COUNT = 1'b1;

endpackage

FILE: design/bloom_filter_insert_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter bit store with double hashing, held in a one-bit-wide
// synchronous memory that is probed once per cycle.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                      Contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  operation, first_hash, second_hash
//  m_axis    out  m_axis_tvalid / m_axis_tready  present
//  cfg       in   i_cfg_we                       filter_size, probe_count
//
// Insert and query step through accepting the item, the two remainder units,
// loading the remainders, one memory access per probe, a last read and
// handing over the result. With no probes or operation 3, the item goes
// from the accept straight to the result.
// Clear sweeps the memory one entry a cycle.
// After reset the same sweep runs over every entry before any transfer.
// A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query #(
    parameter int STORE_BITS = 4096,
    parameter int MAX_PROBES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  bfiq_pkg::t_size       i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // first_hash, second_hash
    input  bfiq_pkg::t_op         s_axis_tuser,  // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata   // present, zero fill
);
    import bfiq_pkg::*;

    localparam int AW = $clog2(STORE_BITS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;
    t_size              r_filter_size;
    t_pcnt              r_probe_count;
    t_op                r_op;
    t_size              r_size;
    t_pcnt              r_probes;
    t_pcnt              r_cnt;
    t_size              r_idx;
    t_size              r_stride;
    logic               r_all;
    logic               r_item;
    logic               r_rd_pend;
    logic               r_rd_data;
    logic [AW-1:0]      r_clr_addr;
    logic               r_out_valid;
    logic               r_out_present;
    logic               r_mem [STORE_BITS];

    t_size              w_act_size;
    t_pcnt              w_act_probes;
    logic               w_accept;
    logic               w_start;
    logic               w_rem1_done;
    logic               w_rem2_done;
    t_size              w_rem1;
    t_size              w_rem2;
    logic [SIZE_W:0]    w_sum;
    logic [SIZE_W:0]    w_wrap;
    t_size              w_next_idx;
    logic [AW+SIZE_W-1:0] w_idx_ext;
    logic               w_mem_we;
    logic               w_mem_wd;
    logic [AW-1:0]      w_mem_addr;
    logic               w_load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_size <= SIZE_W'(4096);
            r_probe_count <= PCNT_W'(4);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_FILTER_SIZE: r_filter_size <= i_cfg_wdata;
                REG_PROBE_COUNT: r_probe_count <= i_cfg_wdata[PCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_filter_size == '0) begin
            w_act_size = SIZE_W'(1);
        end else if (32'(r_filter_size) > 32'(STORE_BITS)) begin
            w_act_size = SIZE_W'(STORE_BITS);
        end else begin
            w_act_size = r_filter_size;
        end
        if (32'(r_probe_count) > 32'(MAX_PROBES)) begin
            w_act_probes = PCNT_W'(MAX_PROBES);
        end else begin
            w_act_probes = r_probe_count;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = w_accept && (w_act_probes != '0)
                           && (s_axis_tuser == OP_INSERT || s_axis_tuser == OP_QUERY);

    bfiq_rem u_rem1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (s_axis_tdata[15:0]),
        .i_divisor  (w_act_size),
        .o_done     (w_rem1_done),
        .o_rem      (w_rem1)
    );

    bfiq_rem u_rem2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (s_axis_tdata[31:16]),
        .i_divisor  (w_act_size),
        .o_done     (w_rem2_done),
        .o_rem      (w_rem2)
    );

    always_comb begin
        w_sum  = {1'b0, r_idx} + {1'b0, r_stride};
        w_wrap = w_sum - {1'b0, r_size};
        if (w_sum >= {1'b0, r_size}) begin
            w_next_idx = w_wrap[SIZE_W-1:0];
        end else begin
            w_next_idx = w_sum[SIZE_W-1:0];
        end
    end

    assign w_idx_ext  = (AW+SIZE_W)'(r_idx);
    assign w_load_out = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        w_mem_we   = 1'b0;
        w_mem_wd   = 1'b0;
        w_mem_addr = w_idx_ext[AW-1:0];
        if (r_state == ST_CLEAR) begin
            w_mem_we   = 1'b1;
            w_mem_addr = r_clr_addr;
        end else if (r_state == ST_PROBE && r_op == OP_INSERT) begin
            w_mem_we = 1'b1;
            w_mem_wd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wd;
        end
        r_rd_data <= r_mem[w_mem_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(STORE_BITS - 1)) begin
                    n_state = r_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == OP_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (w_start) begin
                        n_state = ST_MOD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MOD: begin
                if (w_rem1_done && w_rem2_done) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (7'(r_cnt) + 7'd1 == 7'(r_probes)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_item      <= 1'b0;
            r_clr_addr  <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == ST_PROBE) && (r_op == OP_QUERY);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else begin
                r_clr_addr <= '0;
            end
            if (w_accept) begin
                r_item <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= s_axis_tuser;
            r_size   <= w_act_size;
            r_probes <= w_act_probes;
            r_all    <= 1'b1;
        end else if (r_rd_pend) begin
            r_all <= r_all & r_rd_data;
        end
        if (r_state == ST_MOD) begin
            r_idx    <= w_rem1;
            r_stride <= w_rem2;
            r_cnt    <= '0;
        end else if (r_state == ST_PROBE) begin
            r_idx <= w_next_idx;
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_load_out) begin
            r_out_present <= (r_op == OP_QUERY) && r_all;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_present};

endmodule

FILE: design/bfiq_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_rem
// Restoring remainder unit: a hash value modulo the active filter size,
// one dividend bit per cycle over all sixteen bits of the hash.
// ----------------------------------------------------------------------------
module bfiq_rem (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  bfiq_pkg::t_hash i_dividend,
    input  bfiq_pkg::t_size i_divisor,
    output logic           o_done,
    output bfiq_pkg::t_size o_rem
);
    import bfiq_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    t_hash             r_shift;
    t_size             r_div;
    t_size             r_rem;
    logic [SIZE_W:0]   w_trial;
    logic [SIZE_W:0]   w_sub;
    t_size             n_rem;

    always_comb begin
        w_trial = {r_rem, r_shift[HASH_W-1]};
        w_sub   = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_sub[SIZE_W-1:0];
        end else begin
            n_rem = w_trial[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_div   <= i_divisor;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[HASH_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: tb/bloom_filter_insert_query_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_tb
// Self-checking testbench for the Bloom filter insert and query block. A
// shadow copy of the bit store predicts the present flag of every transfer.
// A short directed part covers the hash extremes, every operation and the
// clamping of both registers. Random phases then mix inserts, queries of
// stored and fresh keys, clears and the unused operation across many filter
// sizes and probe counts. Both sides idle at random, and one long output
// stall backs the block up.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_tb;
    import bfiq_pkg::*;

    localparam int STORE_BITS   = 4096;
    localparam int MAX_PROBES   = 32;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 130;
    localparam int NUM_PHASES   = 12;
    localparam int KEY_POOL_MAX = 48;
    localparam t_op OP_UNUSED   = 2'd3;

    typedef struct {
        t_op   op;
        t_hash h1;
        t_hash h2;
        logic  present;
    } answer_t;

    typedef struct {
        t_hash h1;
        t_hash h2;
    } key_t;

    class bloom_checker;
        bit          shadow_bits[STORE_BITS];
        int unsigned size_reg;
        int unsigned probes_reg;
        answer_t     pending_answers[$];
        int unsigned mismatches;
        int unsigned answers_checked;
        int unsigned hits_seen;
        int unsigned op_counts[4];

        function new();
            foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
            size_reg   = 4096;
            probes_reg = 4;
        endfunction

        function void write_reg(logic addr, t_size value);
            if (addr == REG_FILTER_SIZE) size_reg = value;
            else probes_reg = value[PCNT_W-1:0];
        endfunction

        function void note_request(t_op op, t_hash h1, t_hash h2);
            int unsigned size;
            int unsigned probes;
            int unsigned idx;
            answer_t     ans;
            size   = (size_reg == 0) ? 1 : size_reg;
            size   = (size > STORE_BITS) ? STORE_BITS : size;
            probes = (probes_reg > MAX_PROBES) ? MAX_PROBES : probes_reg;
            ans.op = op;
            ans.h1 = h1;
            ans.h2 = h2;
            ans.present = 1'b0;
            op_counts[op]++;
            case (op)
                OP_INSERT: begin
                    for (int j = 0; j < probes; j++) begin
                        idx = (longint'(h1) + longint'(j) * longint'(h2)) % size;
                        shadow_bits[idx] = 1'b1;
                    end
                end
                OP_QUERY: begin
                    ans.present = 1'b1;
                    for (int j = 0; j < probes; j++) begin
                        idx = (longint'(h1) + longint'(j) * longint'(h2)) % size;
                        if (!shadow_bits[idx]) ans.present = 1'b0;
                    end
                end
                OP_CLEAR: begin
                    foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
                end
                default: begin
                end
            endcase
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(logic present);
            answer_t ans;
            if (pending_answers.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: unexpected result transfer, present %0d", $time, present);
                mismatches++;
                return;
            end
            ans = pending_answers.pop_front();
            answers_checked++;
            if (present === 1'b1 && ans.op == OP_QUERY) hits_seen++;
            if (present !== ans.present) begin
                if (mismatches < 10)
                    $display("%0t: op %0d h1 %h h2 %h: expected present %0d, got %0d",
                             $time, ans.op, ans.h1, ans.h2, ans.present, present);
                mismatches++;
            end
        endfunction

        function void flush_leftover();
            if (pending_answers.size() != 0) begin
                $display("%0d expected results never arrived", pending_answers.size());
                mismatches += pending_answers.size();
                pending_answers.delete();
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    t_size       i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // first_hash, second_hash
    t_op         s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // present, zero fill

    bloom_checker chk = new();
    key_t         inserted_keys[$];
    bit           idle_on = 1'b1;
    bit           hold_req = 1'b0;
    int unsigned  stall_left = 0;
    int unsigned  phases_run = 0;

    bloom_filter_insert_query #(
        .STORE_BITS(STORE_BITS),
        .MAX_PROBES(MAX_PROBES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            chk.check_answer(m_axis_tdata[0]);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Cycle limit reached with %0d results outstanding",
                 chk.pending_answers.size());
        $display("bloom_filter_insert_query test failed");
        $finish;
    end

    // Called at a falling edge; returns at a falling edge with the transfer done.
    task automatic send_item(t_op op, t_hash h1, t_hash h2);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {h2, h1};
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        chk.note_request(op, h1, h2);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (chk.pending_answers.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic addr, t_size value);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = value;
        @(posedge i_clk);
        chk.write_reg(addr, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_filter(t_size size, t_size probes);
        write_reg(REG_FILTER_SIZE, size);
        write_reg(REG_PROBE_COUNT, probes);
        phases_run++;
    endtask

    function automatic t_hash rand_hash();
        case ($urandom_range(0, 15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return t_hash'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_item();
        int   pick;
        key_t key;
        pick = $urandom_range(0, 199);
        if (pick < 3) begin
            inserted_keys.delete();
            send_item(OP_CLEAR, rand_hash(), rand_hash());
        end else if (pick < 9) begin
            send_item(OP_UNUSED, rand_hash(), rand_hash());
        end else if (pick < 85) begin
            key.h1 = rand_hash();
            key.h2 = rand_hash();
            inserted_keys.push_back(key);
            if (inserted_keys.size() > KEY_POOL_MAX) void'(inserted_keys.pop_front());
            send_item(OP_INSERT, key.h1, key.h2);
        end else if (pick < 155 && inserted_keys.size() != 0) begin
            key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            send_item(OP_QUERY, key.h1, key.h2);
        end else begin
            send_item(OP_QUERY, rand_hash(), rand_hash());
        end
    endtask

    initial begin
        int unsigned phase_sizes[NUM_PHASES] = '{4096, 1, 8191, 64, 0, 257, 4095, 1000,
                                                 13, 2048, 4096, 300};
        int unsigned phase_probes[NUM_PHASES] = '{4, 32, 63, 1, 2, 0, 8, 5, 3, 16, 32, 6};

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_FILTER_SIZE;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_INSERT;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_filter(13'd4096, 13'd4);
        send_item(OP_INSERT, 16'h0000, 16'h0000);
        send_item(OP_QUERY,  16'h0000, 16'h0000);
        send_item(OP_QUERY,  16'hFFFF, 16'hFFFF);
        send_item(OP_INSERT, 16'hFFFF, 16'hFFFF);
        send_item(OP_QUERY,  16'hFFFF, 16'hFFFF);
        send_item(OP_UNUSED, 16'hFFFF, 16'h0000);
        send_item(OP_QUERY,  16'h0000, 16'hFFFF);
        send_item(OP_CLEAR,  16'h1234, 16'h5678);
        send_item(OP_QUERY,  16'h0000, 16'h0000);
        drain();
        set_filter(13'd4096, 13'd0);
        send_item(OP_INSERT, 16'h00FF, 16'hFF00);
        send_item(OP_QUERY,  16'hABCD, 16'h1234);
        drain();
        set_filter(13'd8191, 13'd63);
        send_item(OP_INSERT, 16'h0001, 16'h0001);
        send_item(OP_QUERY,  16'h0001, 16'h0001);
        send_item(OP_QUERY,  16'h0000, 16'h0001);
        drain();
        set_filter(13'd0, 13'd1);
        send_item(OP_QUERY,  16'h5555, 16'hAAAA);
        send_item(OP_INSERT, 16'h5555, 16'hAAAA);
        send_item(OP_QUERY,  16'hFFFF, 16'hFFFF);
        drain();
        set_filter(13'd1, 13'd32);
        send_item(OP_QUERY,  16'h8000, 16'h7FFF);
        send_item(OP_CLEAR,  16'hFFFF, 16'hFFFF);
        send_item(OP_QUERY,  16'h8000, 16'h7FFF);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_filter(t_size'(phase_sizes[p]), t_size'(phase_probes[p]));
            idle_on = (p != NUM_PHASES - 1);
            if (p == 3) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) random_item();
            drain();
        end

        repeat (60) @(negedge i_clk);
        chk.flush_leftover();

        $display("Sent %0d inserts, %0d queries, %0d clears and %0d unused operations",
                 chk.op_counts[OP_INSERT], chk.op_counts[OP_QUERY],
                 chk.op_counts[OP_CLEAR], chk.op_counts[OP_UNUSED]);
        $display("over %0d register settings; %0d results checked, %0d queries present",
                 phases_run, chk.answers_checked, chk.hits_seen);
        if (chk.mismatches == 0) begin
            $display("bloom_filter_insert_query test passed");
        end else begin
            $display("%0d mismatches", chk.mismatches);
            $display("bloom_filter_insert_query test failed");
        end
        $finish;
    end

endmodule
